// ----- hdl/amc_pkg.sv -----
`default_nettype none

package amc_pkg;

  // Restoring divider: 18-bit dividend, 9-bit divisor, one quotient bit per stage.
  localparam int DivNumW = 18;
  localparam int DivDenW = 9;

  // Queue between the classify front and the rescale back.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;

  // Blend mode codes; codes above burn act as burn.
  typedef enum logic [3:0] {
    ModeMult     = 4'd0,
    ModeDarken   = 4'd1,
    ModeOverlay  = 4'd2,
    ModeDodge    = 4'd3,
    ModeLinBurn  = 4'd4,
    ModeLinDodge = 4'd5,
    ModeHardMix  = 4'd6,
    ModeSofter   = 4'd7,
    ModeSubtract = 4'd8,
    ModeBurn     = 4'd9
  } mode_e;

  // One classified pixel as handed from front to back.
  typedef struct packed {
    logic       bypass;
    logic       zero;
    logic [7:0] n;
    logic [7:0] d;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } amc_item_t;

  // Pixel data that travels beside the front divider.
  typedef struct packed {
    logic       ext;
    logic [7:0] d;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] nfast;
    logic       use_div;
    logic       inv;
  } amc_fside_t;

endpackage

`default_nettype wire

// ----- hdl/amc_div.sv -----
`default_nettype none

module amc_div
  import amc_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic [DivNumW-1:0] quo_o
);

  logic [DivNumW-1:0] num_q [DivNumW];
  logic [DivDenW-1:0] den_q [DivNumW];
  logic [DivDenW-1:0] rem_q [DivNumW];
  logic [DivNumW-1:0] quo_q [DivNumW];

  // Each stage brings down one dividend bit, MSB first, and settles one quotient bit.
  for (genvar k = 0; k < DivNumW; k++) begin : g_stage
    logic [DivNumW-1:0] num_in;
    logic [DivNumW-1:0] quo_in;
    logic [DivDenW-1:0] den_in;
    logic [DivDenW-1:0] rem_in;
    logic [DivDenW:0]   trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, num_in[DivNumW-1-k]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= num_in;
        den_q[k] <= den_in;
        rem_q[k] <= ge ? DivDenW'(trial - {1'b0, den_in}) : trial[DivDenW-1:0];
        quo_q[k] <= {quo_in[DivNumW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DivNumW-1];

endmodule

`default_nettype wire

// ----- hdl/amc_queue.sv -----
`default_nettype none

module amc_queue
  import amc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  amc_item_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output amc_item_t data_o,
  output logic      empty_o
);

  amc_item_t            mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= QueuePtrW'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= QueuePtrW'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        count_q <= QueueCntW'(count_q + 1'b1);
      end else if (!push_i && pop_i) begin
        count_q <= QueueCntW'(count_q - 1'b1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == QueueCntW'($past(count_q) + 1'b1))
    else $error("queue count did not follow a write");
`endif

endmodule

`default_nettype wire

// ----- hdl/amc_front.sv -----
`default_nettype none

module amc_front
  import amc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mode_e      mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_ext_i,
  input  logic [7:0] in_d_i,
  input  logic [7:0] in_r_i,
  input  logic [7:0] in_g_i,
  input  logic [7:0] in_b_i,
  input  logic [7:0] in_s_i,
  output amc_item_t  item_o,
  output logic       item_valid_o,
  input  logic       item_ready_i
);

  logic               en;
  logic               va_q;
  logic [DivNumW-1:0] vdiv_q;
  logic               ext_q;
  logic [7:0]         d_q, r_q, g_q, b_q, s_q;

  logic [7:0]         ma, mb, den, nfast, burn_x;
  logic               use_div, inv, dbl;
  logic [8:0]         sd_sum;
  logic [9:0]         pos, soft_v;
  logic [8:0]         neg;
  logic [15:0]        prod;
  logic [16:0]        num;
  logic [DivNumW-1:0] div_num;
  logic [DivNumW-1:0] quo;
  amc_fside_t         side_in;
  amc_fside_t         side_q [DivNumW];
  amc_fside_t         side_out;
  logic [7:0]         n;

  // The whole front advances together unless a finished beat waits on a full queue.
  assign en         = !vdiv_q[DivNumW-1] || item_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vdiv_q <= '0;
    end else if (en) begin
      va_q   <= in_valid_i;
      vdiv_q <= {vdiv_q[DivNumW-2:0], va_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ext_q <= in_ext_i;
      d_q   <= in_d_i;
      r_q   <= in_r_i;
      g_q   <= in_g_i;
      b_q   <= in_b_i;
      s_q   <= in_s_i;
    end
  end

  // Classify by mode: either a closed-form alpha or a rounded quotient num/den.
  assign sd_sum = {1'b0, s_q} + {1'b0, d_q};
  assign burn_x = 8'(sd_sum - 9'd255);
  assign pos    = {2'b00, d_q} + {1'b0, d_q, 1'b0};
  assign neg    = {~s_q, 1'b0};
  assign soft_v = pos - {1'b0, neg};

  always_comb begin
    ma      = '0;
    mb      = '0;
    den     = 8'd255;
    use_div = 1'b0;
    inv     = 1'b0;
    dbl     = 1'b0;
    nfast   = '0;
    case (mode_i)
      ModeMult: begin
        ma      = s_q;
        mb      = d_q;
        use_div = 1'b1;
      end
      ModeDarken: begin
        nfast = (s_q < d_q) ? s_q : d_q;
      end
      ModeOverlay: begin
        use_div = 1'b1;
        dbl     = 1'b1;
        if (d_q <= 8'd127) begin
          ma = s_q;
          mb = d_q;
        end else begin
          ma  = ~s_q;
          mb  = ~d_q;
          inv = 1'b1;
        end
      end
      ModeDodge: begin
        if (s_q == 8'd255) begin
          nfast = (d_q == 8'd0) ? 8'd0 : 8'd255;
        end else if (d_q >= ~s_q) begin
          nfast = 8'd255;
        end else begin
          ma      = d_q;
          mb      = 8'd255;
          den     = ~s_q;
          use_div = 1'b1;
        end
      end
      ModeLinBurn: begin
        nfast = sd_sum[8] ? burn_x : 8'd0;
      end
      ModeLinDodge: begin
        if (d_q == 8'd0) begin
          nfast = 8'd0;
        end else begin
          nfast = sd_sum[8] ? 8'd255 : sd_sum[7:0];
        end
      end
      ModeHardMix: begin
        nfast = sd_sum[8] ? 8'd255 : 8'd0;
      end
      ModeSofter: begin
        if (pos <= {1'b0, neg}) begin
          nfast = 8'd0;
        end else begin
          nfast = (soft_v > 10'd255) ? 8'd255 : soft_v[7:0];
        end
      end
      ModeSubtract: begin
        nfast = (d_q > s_q) ? 8'(d_q - s_q) : 8'd0;
      end
      default: begin
        if (d_q == 8'd255) begin
          nfast = 8'd255;
        end else if (s_q == 8'd0) begin
          nfast = 8'd0;
        end else if (~d_q >= s_q) begin
          nfast = 8'd0;
        end else begin
          ma      = burn_x;
          mb      = 8'd255;
          den     = s_q;
          use_div = 1'b1;
        end
      end
    endcase
  end

  // Round half up: floor((2*num + den) / (2*den)).
  assign prod    = ma * mb;
  assign num     = dbl ? {prod, 1'b0} : {1'b0, prod};
  assign div_num = {num, 1'b0} + {10'd0, den};

  amc_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (div_num),
    .den_i ({den, 1'b0}),
    .quo_o (quo)
  );

  // Pixel data rides beside the divider stages.
  assign side_in = '{ext: ext_q, d: d_q, r: r_q, g: g_q, b: b_q,
                     nfast: nfast, use_div: use_div, inv: inv};

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < DivNumW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Final alpha and the pass-through and zero decisions.
  assign side_out = side_q[DivNumW-1];
  assign n = side_out.use_div ? (side_out.inv ? ~quo[7:0] : quo[7:0]) : side_out.nfast;

  assign item_o = '{bypass: (!side_out.ext || side_out.d == 8'd0 || n == side_out.d),
                    zero: (n == 8'd0), n: n, d: side_out.d,
                    r: side_out.r, g: side_out.g, b: side_out.b};
  assign item_valid_o = vdiv_q[DivNumW-1];

endmodule

`default_nettype wire

// ----- hdl/amc_back.sv -----
`default_nettype none

module amc_back
  import amc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  amc_item_t  item_i,
  input  logic       item_valid_i,
  output logic       item_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_alpha_o,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o
);

  logic               en;
  logic [DivNumW-1:0] vb_q;
  logic               vp_q;
  logic               out_valid_q;
  amc_item_t          item_q [DivNumW];
  amc_item_t          pitem_q;
  amc_item_t          dout;
  logic [7:0]         chan_in [3];
  logic [15:0]        p_q [3];
  logic [7:0]         chan_out [3];
  logic [7:0]         alpha_q, red_q, green_q, blue_q;

  // The back advances whenever the output register is free or being drained.
  assign en         = !out_valid_q || out_ready_i;
  assign item_pop_o = en && item_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q        <= '0;
      vp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vb_q        <= {vb_q[DivNumW-2:0], item_valid_i};
      vp_q        <= vb_q[DivNumW-1];
      out_valid_q <= vp_q;
    end
  end

  // Item data rides beside the channel dividers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      item_q[0] <= item_i;
      for (int k = 1; k < DivNumW; k++) begin
        item_q[k] <= item_q[k-1];
      end
      pitem_q <= item_q[DivNumW-1];
    end
  end

  assign chan_in[0] = item_i.r;
  assign chan_in[1] = item_i.g;
  assign chan_in[2] = item_i.b;

  // Per channel: q = round(c*n/d) capped at 255, then p = q*n, then the /255 fold.
  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [15:0]        cn;
    logic [DivNumW-1:0] dnum;
    logic [DivNumW-1:0] quo;
    logic [7:0]         q;
    logic [16:0]        fold;

    assign cn   = chan_in[c] * item_i.n;
    assign dnum = {1'b0, cn, 1'b0} + {10'd0, item_i.d};

    amc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (dnum),
      .den_i ({item_i.d, 1'b0}),
      .quo_o (quo)
    );

    assign q = (quo > DivNumW'(255)) ? 8'd255 : quo[7:0];

    always_ff @(posedge clk_i) begin
      if (en) begin
        p_q[c] <= q * item_q[DivNumW-1].n;
      end
    end

    assign fold        = {1'b0, p_q[c]} + {9'd0, p_q[c][15:8]} + 17'd128;
    assign chan_out[c] = fold[15:8];
  end

  // Output selection: unchanged, cleared or rescaled.
  always_comb begin
    dout = pitem_q;
    if (pitem_q.bypass) begin
      dout = pitem_q;
    end else if (pitem_q.zero) begin
      dout.d = 8'd0;
      dout.r = 8'd0;
      dout.g = 8'd0;
      dout.b = 8'd0;
    end else begin
      dout.d = pitem_q.n;
      dout.r = chan_out[0];
      dout.g = chan_out[1];
      dout.b = chan_out[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha_q <= dout.d;
      red_q   <= dout.r;
      green_q <= dout.g;
      blue_q  <= dout.b;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_alpha_o = alpha_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;

endmodule

`default_nettype wire

// ----- hdl/alpha_mask_composite_pixel.sv -----
`default_nettype none

// Composites one premultiplied ARGB stroke pixel against an 8-bit mask cover
// alpha per beat, using the blend mode held in the configuration register
// (reset: burn). One pixel is accepted every cycle when the output is drained.
// A result passes through the input register, the two 18-stage restoring
// divider pipelines, the queue register and the product and output registers.
// The front has one divider for the new alpha and the back has three in
// parallel for the color rescale. A four-entry queue between front and back
// lets each side stall on its own.
module alpha_mask_composite_pixel
  import amc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: main_alpha[7:0], main_red[15:8], main_green[23:16],
  //        main_blue[31:24], cover_alpha[39:32]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // tuser: in_extent[0]
  input  logic        s_axis_tuser,
  // tdata: out_alpha[7:0], out_red[15:8], out_green[23:16], out_blue[31:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);

  mode_e     blend_mode_q;
  amc_item_t fitem, qitem;
  logic      fvalid, qfull, qempty, qpop;

  // Blend mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q <= ModeBurn;
    end else if (cfg_we_i) begin
      blend_mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  amc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (blend_mode_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_ext_i     (s_axis_tuser),
    .in_d_i       (s_axis_tdata[7:0]),
    .in_r_i       (s_axis_tdata[15:8]),
    .in_g_i       (s_axis_tdata[23:16]),
    .in_b_i       (s_axis_tdata[31:24]),
    .in_s_i       (s_axis_tdata[39:32]),
    .item_o       (fitem),
    .item_valid_o (fvalid),
    .item_ready_i (!qfull)
  );

  amc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fvalid && !qfull),
    .data_i  (fitem),
    .full_o  (qfull),
    .pop_i   (qpop),
    .data_o  (qitem),
    .empty_o (qempty)
  );

  amc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (qitem),
    .item_valid_i (!qempty),
    .item_pop_o   (qpop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_alpha_o  (m_axis_tdata[7:0]),
    .out_red_o    (m_axis_tdata[15:8]),
    .out_green_o  (m_axis_tdata[23:16]),
    .out_blue_o   (m_axis_tdata[31:24])
  );

endmodule

`default_nettype wire
